FILE: rtl/psd_pkg.sv
`timescale 1ns / 1ps
package psd_pkg;

	// coordinate format
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;

	// derived widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int T_W    = SQ_W + 1;
	localparam int HALF_W = SQ_W / 2;
	localparam int PP_W   = 2 * HALF_W;
	localparam int NUM_W  = 2 * SQ_W;
	localparam int QUO_W  = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W = QUO_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	// pipeline depth
	localparam int FRONT_STAGES = 6;
	localparam int LATENCY      = FRONT_STAGES + QUO_W + ROOT_W;

	typedef enum logic [1:0] {
		REG_START  = 2'd0,
		REG_INSIDE = 2'd1,
		REG_END    = 2'd2
	} region_t;

	// control that travels with each beat down the chain
	typedef struct packed {
		logic    vld;
		region_t region;
	} psd_tag_t;

endpackage

FILE: rtl/point_segment_distance.sv
`timescale 1ns / 1ps
// Point to closed segment distance in 3-D.
// A beat is offered by raising start with the nine signed coordinates (query
// point, first end, second end) on their ports; it is taken at any rising
// edge where start is high and busy is low. busy stays low, so one beat can
// enter every cycle.
// Each beat gives one result beat: done is high for one cycle with
// seg_distance = floor(256 * distance) and nearest_region (0 first end
// nearest, 1 interior, 2 second end nearest). The receiver cannot stall;
// results appear in input order. The geometry and product stages are
// followed by a chain of 50 divide cells, one quotient bit per cell, and a
// chain of 25 square root cells, one root bit per cell. Throughput is one
// beat per cycle.
// Reset clears all valid flags at once; beats in flight are dropped and no
// result is given for them.
module point_segment_distance
	import psd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] end_z,
	output logic                         done,
	output logic [ROOT_W-1:0]            seg_distance,
	output logic [1:0]                   nearest_region
);

	psd_tag_t          dv_tag [QUO_W+1];
	logic [SQ_W-1:0]   dv_rem [QUO_W+1];
	logic [QUO_W-1:0]  dv_rq  [QUO_W+1];
	logic [SQ_W-1:0]   dv_den [QUO_W+1];

	psd_tag_t          sq_tag [ROOT_W+1];
	logic [REM_W-1:0]  sq_r   [ROOT_W+1];
	logic [ROOT_W-1:0] sq_q   [ROOT_W+1];
	logic [QUO_W-1:0]  sq_x   [ROOT_W+1];

	assign busy = 1'b0;

	// geometry front end
	psd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.query_x (query_x),
		.query_y (query_y),
		.query_z (query_z),
		.start_x (start_x),
		.start_y (start_y),
		.start_z (start_z),
		.end_x   (end_x),
		.end_y   (end_y),
		.end_z   (end_z),
		.tag     (dv_tag[0]),
		.rem     (dv_rem[0]),
		.rq      (dv_rq[0]),
		.den     (dv_den[0])
	);

	// divide chain, one quotient bit per cell
	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		psd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tag_i  (dv_tag[g]),
			.rem_i  (dv_rem[g]),
			.rq_i   (dv_rq[g]),
			.den_i  (dv_den[g]),
			.tag_o  (dv_tag[g+1]),
			.rem_o  (dv_rem[g+1]),
			.rq_o   (dv_rq[g+1]),
			.den_o  (dv_den[g+1])
		);
	end

	// square root chain, one root bit per cell
	assign sq_tag[0] = dv_tag[QUO_W];
	assign sq_r[0]   = '0;
	assign sq_q[0]   = '0;
	assign sq_x[0]   = dv_rq[QUO_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tag_i  (sq_tag[g]),
			.r_i    (sq_r[g]),
			.q_i    (sq_q[g]),
			.x_i    (sq_x[g]),
			.tag_o  (sq_tag[g+1]),
			.r_o    (sq_r[g+1]),
			.q_o    (sq_q[g+1]),
			.x_o    (sq_x[g+1])
		);
	end

	// result beat
	assign done           = sq_tag[ROOT_W].vld;
	assign seg_distance   = sq_q[ROOT_W];
	assign nearest_region = sq_tag[ROOT_W].region;

	// end regions divide by one, so the fraction bits stay clear
	a_end_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_tag[QUO_W].vld && dv_tag[QUO_W].region != REG_INSIDE)
		|-> dv_rq[QUO_W][2*FRAC_BITS-1:0] == '0)
		else $error("end region quotient has fraction bits");

	// every root beat came out of the divide chain and through the square root chain
	a_sqrt_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(dv_tag[QUO_W].vld, ROOT_W))
		else $error("result beat without a divide beat");

	// remainder of the root never exceeds twice the root
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> sq_r[ROOT_W] <= {sq_q[ROOT_W], 1'b0})
		else $error("square root remainder out of range");

	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> nearest_region != 2'd3)
		else $error("bad region code");

endmodule

FILE: rtl/psd_front.sv
`timescale 1ns / 1ps
module psd_front
	import psd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] end_z,
	output psd_tag_t                     tag,
	output logic [SQ_W-1:0]              rem,
	output logic [QUO_W-1:0]             rq,
	output logic [SQ_W-1:0]              den
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [DIFF_W-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [DIFF_W-1:0] wx_s1, wy_s1, wz_s1;

	logic signed [PROD_W-1:0] ddx_s2, ddy_s2, ddz_s2;
	logic signed [PROD_W-1:0] vvx_s2, vvy_s2, vvz_s2;
	logic signed [PROD_W-1:0] wwx_s2, wwy_s2, wwz_s2;
	logic signed [PROD_W-1:0] vdx_s2, vdy_s2, vdz_s2;

	logic [SQ_W-1:0]         dd_s3, vv_s3, ww_s3;
	logic signed [T_W-1:0]   t_s3;

	logic                    t_neg, t_gt;
	region_t                 region_s4;
	logic                    degen_s4;
	logic [SQ_W-1:0]         dd_s4, vv_s4, ww_s4;
	logic [PP_W-1:0]         vd_hh_s4, vd_hl_s4, vd_lh_s4, vd_ll_s4;
	logic [PP_W-1:0]         tt_hh_s4, tt_hl_s4, tt_ll_s4;

	region_t                 region_s5;
	logic                    degen_s5;
	logic [SQ_W-1:0]         dd_s5, vv_s5, ww_s5;
	logic [NUM_W-1:0]        vd_s5, tt_s5;

	logic [NUM_W-1:0]        num_sel;
	logic [SQ_W-1:0]         den_sel;
	region_t                 region_s6;

	// stage 1: difference vectors
	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(end_x) - DIFF_W'(start_x);
		dy_s1 <= DIFF_W'(end_y) - DIFF_W'(start_y);
		dz_s1 <= DIFF_W'(end_z) - DIFF_W'(start_z);
		vx_s1 <= DIFF_W'(query_x) - DIFF_W'(start_x);
		vy_s1 <= DIFF_W'(query_y) - DIFF_W'(start_y);
		vz_s1 <= DIFF_W'(query_z) - DIFF_W'(start_z);
		wx_s1 <= DIFF_W'(query_x) - DIFF_W'(end_x);
		wy_s1 <= DIFF_W'(query_y) - DIFF_W'(end_y);
		wz_s1 <= DIFF_W'(query_z) - DIFF_W'(end_z);
	end

	// stage 2: component products
	always_ff @(posedge clk) begin
		ddx_s2 <= dx_s1 * dx_s1;
		ddy_s2 <= dy_s1 * dy_s1;
		ddz_s2 <= dz_s1 * dz_s1;
		vvx_s2 <= vx_s1 * vx_s1;
		vvy_s2 <= vy_s1 * vy_s1;
		vvz_s2 <= vz_s1 * vz_s1;
		wwx_s2 <= wx_s1 * wx_s1;
		wwy_s2 <= wy_s1 * wy_s1;
		wwz_s2 <= wz_s1 * wz_s1;
		vdx_s2 <= vx_s1 * dx_s1;
		vdy_s2 <= vy_s1 * dy_s1;
		vdz_s2 <= vz_s1 * dz_s1;
	end

	// stage 3: squared lengths and projection
	always_ff @(posedge clk) begin
		dd_s3 <= $unsigned(ddx_s2) + $unsigned(ddy_s2) + $unsigned(ddz_s2);
		vv_s3 <= $unsigned(vvx_s2) + $unsigned(vvy_s2) + $unsigned(vvz_s2);
		ww_s3 <= $unsigned(wwx_s2) + $unsigned(wwy_s2) + $unsigned(wwz_s2);
		t_s3  <= T_W'(vdx_s2) + T_W'(vdy_s2) + T_W'(vdz_s2);
	end

	// stage 4: region decision and half-width partial products
	assign t_neg = t_s3[T_W-1];
	assign t_gt  = !t_neg && (t_s3[SQ_W-1:0] > dd_s3);

	always_ff @(posedge clk) begin
		region_s4 <= t_neg ? REG_START : (t_gt ? REG_END : REG_INSIDE);
		degen_s4  <= (dd_s3 == '0);
		dd_s4     <= dd_s3;
		vv_s4     <= vv_s3;
		ww_s4     <= ww_s3;
		vd_hh_s4  <= vv_s3[SQ_W-1:HALF_W] * dd_s3[SQ_W-1:HALF_W];
		vd_hl_s4  <= vv_s3[SQ_W-1:HALF_W] * dd_s3[HALF_W-1:0];
		vd_lh_s4  <= vv_s3[HALF_W-1:0] * dd_s3[SQ_W-1:HALF_W];
		vd_ll_s4  <= vv_s3[HALF_W-1:0] * dd_s3[HALF_W-1:0];
		tt_hh_s4  <= t_s3[SQ_W-1:HALF_W] * t_s3[SQ_W-1:HALF_W];
		tt_hl_s4  <= t_s3[SQ_W-1:HALF_W] * t_s3[HALF_W-1:0];
		tt_ll_s4  <= t_s3[HALF_W-1:0] * t_s3[HALF_W-1:0];
	end

	// stage 5: full products |v|^2 |d|^2 and t^2
	always_ff @(posedge clk) begin
		region_s5 <= region_s4;
		degen_s5  <= degen_s4;
		dd_s5     <= dd_s4;
		vv_s5     <= vv_s4;
		ww_s5     <= ww_s4;
		vd_s5     <= (NUM_W'(vd_hh_s4) << (2 * HALF_W))
			+ ((NUM_W'(vd_hl_s4) + NUM_W'(vd_lh_s4)) << HALF_W)
			+ NUM_W'(vd_ll_s4);
		tt_s5     <= (NUM_W'(tt_hh_s4) << (2 * HALF_W))
			+ (NUM_W'(tt_hl_s4) << (HALF_W + 1))
			+ NUM_W'(tt_ll_s4);
	end

	// stage 6: pick dividend and divisor; end regions divide by one
	always_comb begin
		num_sel = NUM_W'(vv_s5);
		den_sel = SQ_W'(1);
		if (region_s5 == REG_END) begin
			num_sel = NUM_W'(ww_s5);
		end else if (region_s5 == REG_INSIDE && !degen_s5) begin
			num_sel = vd_s5 - tt_s5;
			den_sel = dd_s5;
		end
	end

	always_ff @(posedge clk) begin
		region_s6 <= region_s5;
		rem       <= num_sel[NUM_W-1:SQ_W];
		rq        <= {num_sel[SQ_W-1:0], {(2 * FRAC_BITS){1'b0}}};
		den       <= den_sel;
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign tag = '{vld: vld_s6, region: region_s6};

endmodule

FILE: rtl/psd_div_cell.sv
`timescale 1ns / 1ps
module psd_div_cell
	import psd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  psd_tag_t         tag_i,
	input  logic [SQ_W-1:0]  rem_i,
	input  logic [QUO_W-1:0] rq_i,
	input  logic [SQ_W-1:0]  den_i,
	output psd_tag_t         tag_o,
	output logic [SQ_W-1:0]  rem_o,
	output logic [QUO_W-1:0] rq_o,
	output logic [SQ_W-1:0]  den_o
);

	logic [SQ_W:0] trial;
	logic [SQ_W:0] diff;
	logic          ge;
	logic          vld_q;
	region_t       region_q;

	// one restoring step: bring down a dividend bit, try the divisor
	assign trial = {rem_i, rq_i[QUO_W-1]};
	assign diff  = trial - {1'b0, den_i};
	assign ge    = (trial >= {1'b0, den_i});

	always_ff @(posedge clk) begin
		rem_o    <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
		rq_o     <= {rq_i[QUO_W-2:0], ge};
		den_o    <= den_i;
		region_q <= tag_i.region;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tag_i.vld;
		end
	end

	assign tag_o = '{vld: vld_q, region: region_q};

endmodule

FILE: rtl/psd_sqrt_cell.sv
`timescale 1ns / 1ps
module psd_sqrt_cell
	import psd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  psd_tag_t          tag_i,
	input  logic [REM_W-1:0]  r_i,
	input  logic [ROOT_W-1:0] q_i,
	input  logic [QUO_W-1:0]  x_i,
	output psd_tag_t          tag_o,
	output logic [REM_W-1:0]  r_o,
	output logic [ROOT_W-1:0] q_o,
	output logic [QUO_W-1:0]  x_o
);

	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] test;
	logic [REM_W+1:0] diff;
	logic             ge;
	logic             vld_q;
	region_t          region_q;

	// one root bit: bring down two radicand bits, try 4q+1
	assign trial = {r_i, x_i[QUO_W-1:QUO_W-2]};
	assign test  = (REM_W + 2)'({q_i, 2'b01});
	assign diff  = trial - test;
	assign ge    = (trial >= test);

	always_ff @(posedge clk) begin
		r_o      <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		q_o      <= {q_i[ROOT_W-2:0], ge};
		x_o      <= {x_i[QUO_W-3:0], 2'b00};
		region_q <= tag_i.region;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tag_i.vld;
		end
	end

	assign tag_o = '{vld: vld_q, region: region_q};

endmodule
